// ----- design/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg - shared types and constants for the descrambler slot allocator
// Command and outcome codes, field widths and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

    localparam int CMD_W       = 2;
    localparam int ADAPTER_W   = 4;
    localparam int ID_W        = 12;
    localparam int SLOT_W      = 6;
    localparam int OUTCOME_W   = 3;
    localparam int NUM_SLOTS_W = 7;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [NUM_SLOTS_W-1:0] DEFAULT_SLOTS = 7'd16;

    // register index carried by paddr[2]
    localparam logic REG_NUM_SLOTS = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_EXISTING = 3'd0,
        OC_CLAIMED  = 3'd1,
        OC_FALLBACK = 3'd2,
        OC_RELEASED = 3'd3,
        OC_NOTFOUND = 3'd4,
        OC_CLEARED  = 3'd5
    } t_outcome;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_CLAIM,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_CLEAR,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- design/dsa_mod_unit.sv -----
// ----------------------------------------------------------------------------
// dsa_mod_unit - iterative remainder of a program id by the slot count
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_mod_unit
    import dsa_pkg::*;
#(
    parameter int DW = 7
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [ID_W-1:0] i_dividend,
    input  wire logic [DW-1:0]   i_divisor,
    output logic                 o_done,
    output logic [DW-1:0]        o_rem
);

    localparam int CNT_W = $clog2(ID_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ID_W-1:0]  r_dvd;
    logic [DW-1:0]    r_div;
    logic [DW-1:0]    r_rem;
    logic [DW:0]      w_trial;
    logic [DW:0]      w_next;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[ID_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            w_next = w_trial - {1'b0, r_div};
        end else begin
            w_next = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ID_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ID_W-2:0], 1'b0};
            r_rem <= w_next[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- design/descrambler_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// descrambler_slot_allocator_unit - owner-tagged descrambler slot tables
// One table of MAX_SLOTS slots per adapter, each slot free or owned by a
// program id. Allocate, release and clear requests walk the table through
// a memory with one read port and one write port under a small sequencer.
//
//   channel   direction  handshake                 word
//   request   in         i_in_valid / o_in_ready   i_cmd, i_adapter, i_program_id
//   result    out        o_out_valid / i_out_ready o_slot, o_outcome
//   config    in         psel/penable/pwrite       num_slots at byte address 0
//
// Sequence: allocate and release read one slot at a time (address, then
// compare), up to a full scan of the n active slots; an allocate that
// finds the table full then runs the bit-serial remainder. A clear
// writes MAX_SLOTS slots, one per cycle. Invalid adapter and unused
// commands go straight from accept to emit.
// Reset: a clearing pass over all ADAPTERS*MAX_SLOTS entries sweeps the memory
// first; no request word is taken meanwhile, configuration writes are.
// Stalls: a result word waits in the output register while the next request
// is accepted; the sequencer holds its own result until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module descrambler_slot_allocator_unit
    import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = 64,
    parameter int ADAPTERS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [ADAPTER_W-1:0]  i_adapter,
    input  wire logic [ID_W-1:0]       i_program_id,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [OUTCOME_W-1:0]       o_outcome,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int DEPTH  = ADAPTERS * MAX_SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW     = (ADAPTERS > 1) ? $clog2(ADAPTERS) : 1;
    localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW     = $clog2(MAX_SLOTS + 1);
    localparam int ENTRY_W = ID_W + 1;

    // ---- configuration register ---------------------------------------------
    logic [NUM_SLOTS_W-1:0] r_num_slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_slots <= DEFAULT_SLOTS;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NUM_SLOTS)) begin
            r_num_slots <= pwdata[NUM_SLOTS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_SLOTS) ?
                    APB_DATA_W'(r_num_slots) : '0;

    // active slot count: zero means the default, limit to the table size
    logic [NUM_SLOTS_W-1:0] w_req_slots;
    logic [CW-1:0]          w_active;

    always_comb begin
        w_req_slots = (r_num_slots == '0) ? DEFAULT_SLOTS : r_num_slots;
        if (32'(w_req_slots) > 32'(MAX_SLOTS)) begin
            w_active = CW'(MAX_SLOTS);
        end else begin
            w_active = CW'(w_req_slots);
        end
    end

    // ---- slot memory: {valid, owner} per entry ------------------------------
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_we;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[w_raddr];
    end

    // ---- sequencer registers -------------------------------------------------
    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [AW-1:0]      r_adapter, n_adapter;
    logic [ID_W-1:0]    r_id, n_id;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_free_found, n_free_found;
    logic [SW-1:0]      r_free_idx, n_free_idx;
    logic [ADDR_W-1:0]  r_init_addr, n_init_addr;
    logic [SLOT_W-1:0]  r_res_slot, n_res_slot;
    t_outcome           r_res_outcome, n_res_outcome;
    logic               r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    t_outcome           r_out_outcome, n_out_outcome;

    logic               w_mod_start;
    logic               w_mod_done;
    logic [CW-1:0]      w_mod_rem;

    logic [ADDR_W-1:0]  w_base;
    logic [ADDR_W-1:0]  w_scan_addr;
    logic               w_match;
    logic               w_free;
    logic               w_last;
    logic               w_in_take;
    logic               w_out_free;

    assign w_base      = ADDR_W'(r_adapter) * ADDR_W'(MAX_SLOTS);
    assign w_scan_addr = w_base + ADDR_W'(r_idx);
    assign w_raddr     = w_scan_addr;
    assign w_match     = r_rdata[ID_W] && (r_rdata[ID_W-1:0] == r_id);
    assign w_free      = !r_rdata[ID_W];
    assign w_last      = (r_idx == CW'(r_n - 1'b1));
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    dsa_mod_unit #(
        .DW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_id),
        .i_divisor  (r_n),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_adapter     <= n_adapter;
        r_id          <= n_id;
        r_n           <= n_n;
        r_idx         <= n_idx;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_res_slot    <= n_res_slot;
        r_res_outcome <= n_res_outcome;
        r_out_slot    <= n_out_slot;
        r_out_outcome <= n_out_outcome;
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_adapter     = r_adapter;
        n_id          = r_id;
        n_n           = r_n;
        n_idx         = r_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_init_addr   = r_init_addr;
        n_res_slot    = r_res_slot;
        n_res_outcome = r_res_outcome;
        n_out_valid   = r_out_valid;
        n_out_slot    = r_out_slot;
        n_out_outcome = r_out_outcome;
        o_in_ready    = 1'b0;
        w_we          = 1'b0;
        w_waddr       = w_scan_addr;
        w_wdata       = '0;
        w_mod_start   = 1'b0;

        // drop the output word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // sweep the whole memory to free after reset
            ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_init_addr;
                n_init_addr = r_init_addr + 1'b1;
                if (r_init_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_take) begin
                    n_cmd        = i_cmd;
                    n_adapter    = AW'(i_adapter);
                    n_id         = i_program_id;
                    n_n          = w_active;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_res_slot   = '0;
                    if (32'(i_adapter) >= 32'(ADAPTERS)) begin
                        // adapter out of range: answer without touching the table
                        case (i_cmd)
                            CMD_ALLOC:   n_res_outcome = OC_FALLBACK;
                            CMD_CLEAR:   n_res_outcome = OC_CLEARED;
                            default:     n_res_outcome = OC_NOTFOUND;
                        endcase
                        n_state = ST_EMIT;
                    end else begin
                        case (i_cmd)
                            CMD_ALLOC, CMD_RELEASE: n_state = ST_READ;
                            CMD_CLEAR:              n_state = ST_CLEAR;
                            default: begin
                                n_res_outcome = OC_NOTFOUND;
                                n_state       = ST_EMIT;
                            end
                        endcase
                    end
                end
            end

            // address the slot at r_idx; data is back next cycle
            ST_READ: begin
                n_state = ST_CHECK;
            end

            ST_CHECK: begin
                if (w_match) begin
                    n_res_slot = SLOT_W'(r_idx);
                    if (r_cmd == CMD_RELEASE) begin
                        w_we          = 1'b1;
                        n_res_outcome = OC_RELEASED;
                    end else begin
                        n_res_outcome = OC_EXISTING;
                    end
                    n_state = ST_EMIT;
                end else begin
                    // remember the lowest free slot for a later claim
                    if (w_free && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = SW'(r_idx);
                    end
                    if (w_last) begin
                        if (r_cmd == CMD_RELEASE) begin
                            n_res_slot    = '0;
                            n_res_outcome = OC_NOTFOUND;
                            n_state       = ST_EMIT;
                        end else if (r_free_found || w_free) begin
                            n_state = ST_CLAIM;
                        end else begin
                            n_state = ST_MOD_START;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end

            ST_CLAIM: begin
                w_we          = 1'b1;
                w_waddr       = w_base + ADDR_W'(r_free_idx);
                w_wdata       = {1'b1, r_id};
                n_res_slot    = SLOT_W'(r_free_idx);
                n_res_outcome = OC_CLAIMED;
                n_state       = ST_EMIT;
            end

            // table full: fall back to id modulo the active count
            ST_MOD_START: begin
                w_mod_start = 1'b1;
                n_state     = ST_MOD_WAIT;
            end

            ST_MOD_WAIT: begin
                if (w_mod_done) begin
                    n_res_slot    = SLOT_W'(w_mod_rem);
                    n_res_outcome = OC_FALLBACK;
                    n_state       = ST_EMIT;
                end
            end

            // free every slot of the adapter, active or not
            ST_CLEAR: begin
                w_we  = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == CW'(MAX_SLOTS - 1)) begin
                    n_res_slot    = '0;
                    n_res_outcome = OC_CLEARED;
                    n_state       = ST_EMIT;
                end
            end

            // hold the result until the output register frees
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_slot    = r_res_slot;
                    n_out_outcome = r_res_outcome;
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_slot      = r_out_slot;
    assign o_outcome   = r_out_outcome;

endmodule

`default_nettype wire

// ----- tb/sv/dsa_slot_checker.sv -----
// ----------------------------------------------------------------------------
// dsa_slot_checker - result checker for the descrambler slot allocator
// Watches the request, result and configuration channels, keeps a private
// copy of every adapter's slot table and of num_slots, predicts the answer
// to each accepted request and compares each accepted result word with the
// oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_slot_checker
    import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = 64,
    parameter int ADAPTERS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [ADAPTER_W-1:0]  i_adapter,
    input  wire logic [ID_W-1:0]       i_program_id,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [SLOT_W-1:0]     i_slot,
    input  wire logic [OUTCOME_W-1:0]  i_outcome,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    input  wire logic                  i_pready,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [OUTCOME_W-1:0] outcome;
    } t_answer;

    // two-state counters start at zero
    logic                   slot_taken [ADAPTERS][MAX_SLOTS];
    logic [ID_W-1:0]        slot_holder [ADAPTERS][MAX_SLOTS];
    logic [NUM_SLOTS_W-1:0] num_slots_q;
    t_answer                expected_answers [$];
    int                     answers_seen;
    int                     mismatch_count;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
        o_fail_count = mismatch_count;
    endtask

    // Work out the answer to one request and apply its effect on the tables.
    function automatic t_answer predict_slot_answer(input logic [CMD_W-1:0] cmd,
                                                    input logic [ADAPTER_W-1:0] adp,
                                                    input logic [ID_W-1:0] id);
        t_answer ans;
        int      active;
        int      hit;
        int      vacant;
        int      fallback;
        bit      in_range;
        ans.slot    = '0;
        ans.outcome = OC_NOTFOUND;
        active      = (num_slots_q == '0) ? int'(DEFAULT_SLOTS) : int'(num_slots_q);
        if (active > MAX_SLOTS) active = MAX_SLOTS;
        in_range = int'(adp) < ADAPTERS;
        hit      = -1;
        vacant   = -1;
        if (in_range) begin
            for (int s = active - 1; s >= 0; s--) begin
                if (slot_taken[adp][s] && slot_holder[adp][s] == id) hit = s;
                if (!slot_taken[adp][s]) vacant = s;
            end
        end
        case (cmd)
            CMD_ALLOC: begin
                if (!in_range) begin
                    ans.outcome = OC_FALLBACK;
                end else if (hit >= 0) begin
                    ans.slot    = hit[SLOT_W-1:0];
                    ans.outcome = OC_EXISTING;
                end else if (vacant >= 0) begin
                    slot_taken[adp][vacant]  = 1'b1;
                    slot_holder[adp][vacant] = id;
                    ans.slot    = vacant[SLOT_W-1:0];
                    ans.outcome = OC_CLAIMED;
                end else begin
                    fallback    = int'(id) % active;
                    ans.slot    = fallback[SLOT_W-1:0];
                    ans.outcome = OC_FALLBACK;
                end
            end
            CMD_RELEASE: begin
                if (in_range && hit >= 0) begin
                    slot_taken[adp][hit]  = 1'b0;
                    slot_holder[adp][hit] = '0;
                    ans.slot    = hit[SLOT_W-1:0];
                    ans.outcome = OC_RELEASED;
                end
            end
            CMD_CLEAR: begin
                if (in_range) begin
                    for (int s = 0; s < MAX_SLOTS; s++) begin
                        slot_taken[adp][s]  = 1'b0;
                        slot_holder[adp][s] = '0;
                    end
                end
                ans.outcome = OC_CLEARED;
            end
            default: ans.outcome = OC_NOTFOUND;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int a = 0; a < ADAPTERS; a++) begin
                for (int s = 0; s < MAX_SLOTS; s++) begin
                    slot_taken[a][s]  = 1'b0;
                    slot_holder[a][s] = '0;
                end
            end
            num_slots_q = DEFAULT_SLOTS;
            expected_answers.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[2] == REG_NUM_SLOTS) begin
                num_slots_q = i_pwdata[NUM_SLOTS_W-1:0];
            end
            // the result taken at this edge always belongs to an earlier request
            if (i_out_valid && i_out_ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result word %0d (slot %0d outcome %0d) %s",
                                              answers_seen, i_slot, i_outcome,
                                              "arrived with nothing pending"));
                end else begin
                    want = expected_answers.pop_front();
                    if (i_slot !== want.slot) begin
                        report_mismatch($sformatf("result word %0d slot %0d, expected %0d",
                                                  answers_seen, i_slot, want.slot));
                    end
                    if (i_outcome !== want.outcome) begin
                        report_mismatch($sformatf("result word %0d outcome %0d, expected %0d",
                                                  answers_seen, i_outcome, want.outcome));
                    end
                end
                answers_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_answers.push_back(predict_slot_answer(i_cmd, i_adapter,
                                                               i_program_id));
            end
        end
        o_pending = expected_answers.size();
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for descrambler_slot_allocator_unit
// Drives request words and num_slots writes, idles and stalls both channels
// in several phases and leaves all prediction and comparison to the checker
// beside the block. A watchdog ends the run when nothing moves for too long.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import dsa_pkg::*;

    localparam int MAX_SLOTS       = 64;
    localparam int ADAPTERS        = 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int MAX_POOL        = MAX_SLOTS + 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 200;
    // reset sweep of all 1024 entries, a long hold-off and a full 64-slot scan,
    // taken several times over
    localparam int WATCHDOG_LIMIT  = 10000;

    // the spare command code has no name in the package
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_SLOTS = {REG_NUM_SLOTS, 2'b00};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    wire logic             o_in_ready;
    logic [CMD_W-1:0]      i_cmd;
    logic [ADAPTER_W-1:0]  i_adapter;
    logic [ID_W-1:0]       i_program_id;
    wire logic             o_out_valid;
    logic                  i_out_ready;
    wire logic [SLOT_W-1:0]    o_slot;
    wire logic [OUTCOME_W-1:0] o_outcome;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire logic [APB_DATA_W-1:0] prdata;
    wire logic             pready;

    int fail_count;
    int pending_answers;
    int idle_cycles;
    int recv_stall_pct;
    // hold-off requests: the stimulus bumps hold_ask, the receiver answers
    int hold_ask;
    int hold_done;

    always #2 i_clk = ~i_clk;

    descrambler_slot_allocator_unit #(
        .MAX_SLOTS(MAX_SLOTS),
        .ADAPTERS (ADAPTERS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_adapter   (i_adapter),
        .i_program_id(i_program_id),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_slot      (o_slot),
        .o_outcome   (o_outcome),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dsa_slot_checker #(
        .MAX_SLOTS(MAX_SLOTS),
        .ADAPTERS (ADAPTERS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_adapter   (i_adapter),
        .i_program_id(i_program_id),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_slot      (o_slot),
        .i_outcome   (o_outcome),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending_answers)
    );

    // Offer one request word from the current falling edge, hold it until it
    // is taken, then return at the next falling edge with valid still high.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [ADAPTER_W-1:0] adp,
                                input logic [ID_W-1:0] id);
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_adapter    <= adp;
        i_program_id <= id;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every expected result word has come back.
    task automatic wait_for_answers();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_answers != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write num_slots over the APB port with the block idle: setup, then access.
    task automatic write_num_slots(input logic [NUM_SLOTS_W-1:0] value);
        wait_for_answers();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_NUM_SLOTS;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: random stalls at the phase's rate, or a long hold-off when
    // the stimulus asks for one, counted here in cycles.
    initial begin
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_ask != hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = hold_ask;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(negedge i_clk);
            end
        end
    end

    // Watchdog: count cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pwrite)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("descrambler_slot_allocator_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                     phase_slots [PHASES];
        int                     send_idle_pct [4];
        int                     stall_pct [4];
        logic [ID_W-1:0]        id_pool [MAX_POOL];
        logic [ADAPTER_W-1:0]   hot_adp [2];
        logic [NUM_SLOTS_W-1:0] slots_cfg;
        logic [CMD_W-1:0]       cmd;
        logic [ADAPTER_W-1:0]   adp;
        logic [ID_W-1:0]        id;
        int                     active;
        int                     pool_size;
        int                     mode;
        int                     r;

        // extremes first, then small counts that fill quickly, one random
        phase_slots   = '{1, 64, 0, 127, 3, 16, 0, 2};
        send_idle_pct = '{0, 58, 0, 21};
        stall_pct     = '{0, 0, 58, 21};

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cmd          = CMD_ALLOC;
        i_adapter      = '0;
        i_program_id   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        recv_stall_pct = 0;
        hold_ask       = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: two active slots so that the table fills at once.
        write_num_slots(7'd2);
        send_request(CMD_ALLOC,   4'd0,  12'd0);      // claim slot 0
        send_request(CMD_ALLOC,   4'd0,  12'd0);      // same id finds its slot
        send_request(CMD_ALLOC,   4'd0,  12'd4095);   // claim slot 1
        send_request(CMD_ALLOC,   4'd0,  12'd7);      // table full: id modulo count
        send_request(CMD_RELEASE, 4'd0,  12'd0);      // free slot 0
        send_request(CMD_RELEASE, 4'd0,  12'd0);      // nothing owned any more
        send_request(CMD_ALLOC,   4'd0,  12'd7);      // reuse the lowest free slot
        send_request(CMD_ALLOC,   4'd15, 12'd4095);   // top adapter, top id
        send_request(CMD_SPARE,   4'd15, 12'd4095);   // unused command code
        send_request(CMD_CLEAR,   4'd15, 12'd0);
        send_request(CMD_RELEASE, 4'd15, 12'd4095);   // gone after the clear
        send_request(CMD_CLEAR,   4'd0,  12'd4095);
        send_request(CMD_ALLOC,   4'd0,  12'd5);
        send_request(CMD_ALLOC,   4'd3,  12'd10);
        send_request(CMD_ALLOC,   4'd3,  12'd11);     // slot 1 of adapter 3
        // shrink to one slot: slot 1 is no longer searched or released
        write_num_slots(7'd1);
        send_request(CMD_ALLOC,   4'd3,  12'd11);
        send_request(CMD_RELEASE, 4'd3,  12'd11);
        send_request(CMD_CLEAR,   4'd3,  12'd0);      // a clear still frees slot 1
        write_num_slots(7'd2);
        send_request(CMD_ALLOC,   4'd3,  12'd11);
        send_request(CMD_ALLOC,   4'd3,  12'd2730);
        send_request(CMD_ALLOC,   4'd3,  12'd1365);   // full again

        // Random part: hot adapters and a small id pool per phase, so that
        // tables fill, ids meet their own slots and releases hit.
        for (int phase = 0; phase < PHASES; phase++) begin
            slots_cfg = (phase == 6) ? NUM_SLOTS_W'($urandom_range(127))
                                     : NUM_SLOTS_W'(phase_slots[phase]);
            write_num_slots(slots_cfg);
            active    = (slots_cfg == '0) ? int'(DEFAULT_SLOTS) : int'(slots_cfg);
            if (active > MAX_SLOTS) active = MAX_SLOTS;
            pool_size = active + 3;
            for (int p = 0; p < MAX_POOL; p++) id_pool[p] = ID_W'($urandom_range(4095));
            hot_adp[0] = ADAPTER_W'($urandom_range(15));
            hot_adp[1] = ADAPTER_W'($urandom_range(15));
            mode           = phase % 4;
            recv_stall_pct = stall_pct[mode];

            // fill the block: the receiver holds off while words keep coming
            if (phase == 2) hold_ask = hold_ask + 1;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // halfway through, pause the sender until all results are in
                if (k == ITEMS_PER_PHASE / 2) wait_for_answers();
                while ($urandom_range(99) < send_idle_pct[mode]) begin
                    i_in_valid <= 1'b0;
                    @(negedge i_clk);
                end
                r = $urandom_range(99);
                if (r < 62)      cmd = CMD_ALLOC;
                else if (r < 90) cmd = CMD_RELEASE;
                else if (r < 94) cmd = CMD_CLEAR;
                else             cmd = CMD_SPARE;
                adp = ($urandom_range(99) < 85) ? hot_adp[$urandom_range(1)]
                                                : ADAPTER_W'($urandom_range(15));
                id  = ($urandom_range(99) < 85) ? id_pool[$urandom_range(pool_size - 1)]
                                                : ID_W'($urandom_range(4095));
                send_request(cmd, adp, id);
            end
        end

        // Drain, then leave room for any stray result word before the verdict.
        wait_for_answers();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("descrambler_slot_allocator_unit test passed");
        end else begin
            $display("descrambler_slot_allocator_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/dsa_pkg.sv
design/dsa_mod_unit.sv
design/descrambler_slot_allocator_unit.sv
tb/sv/dsa_slot_checker.sv
tb/sv/tb_top.sv
